// File: rtl/assert_macros.svh
// assertion macros used by the checker file chd_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define CHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/chd_pkg.sv
// types, constants and helpers for the chunked body decoder
// no dependencies
package chd_pkg;

    localparam int unsigned LEN_BITS = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [15:0] MAX_LINE_RESET = 16'd1024;
    localparam logic [15:0] LINE_SAT       = 16'hFFFF;
    localparam logic [31:0] TOTAL_SAT      = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_SIZE   = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd2;
    localparam logic [2:0] ERR_BAD_TERM   = 3'd3;
    localparam logic [2:0] ERR_NO_COLON   = 3'd4;
    localparam logic [2:0] ERR_LINE_LONG  = 3'd5;

    typedef enum logic [2:0] {
        PH_SIZE_FIRST,
        PH_SIZE_DIGITS,
        PH_SIZE_EXT,
        PH_DATA,
        PH_AFTER_DATA,
        PH_TRAILER,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        chunk_end;
        logic [31:0] body_length;
        logic [2:0]  error_code;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.valid = 1'b0;
            h.value = 4'd0;
        end
        return h;
    endfunction

endpackage

// File: rtl/chd_out_buf.sv
// result register with a one-entry skid stage for the chunked body decoder
// depends on chd_pkg
module chd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  chd_pkg::t_result i_result,
    output logic             o_full,
    output logic             o_valid,
    output chd_pkg::t_result o_result,
    input  logic             i_stall
);

    logic             r_valid;
    logic             r_skid_valid;
    chd_pkg::t_result r_data;
    chd_pkg::t_result r_skid;
    logic             out_free;

    // main register can load when empty or being emptied this cycle
    assign out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_data <= r_skid;
            end else if (i_push) begin
                r_data <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_valid;
    assign o_result = r_data;

endmodule

// File: rtl/chunked_body_decoder.sv
// top level of the chunked body decoder: parse state machine and ports
// depends on chd_pkg and chd_out_buf
//
// usage
// - input channel (i_in_valid / o_in_stall) carries one item per cycle while
//   o_in_stall is low: i_mode 0 with a body byte in i_in_byte, or i_mode 1 to
//   restart for a new body (clears all parse state and any latched error, no result)
// - each item is decoded in the cycle it is accepted; at most one result
//   item goes to the output channel (o_out_valid / i_out_stall) through the
//   result register: a data byte, body complete with its length, or an error
// - throughput is one item per cycle while o_in_stall is low, set by the single
//   parse step between the state registers
// - a skid stage behind the result register keeps input flowing for one
//   extra item while the receiver stalls; o_in_stall rises only once the
//   skid entry is full, and is driven from a register
// - after an error, or after body complete, bytes produce no result until
//   a restart item
// - i_cfg_valid / o_cfg_ready write max_line_len; ready is always high, and
//   writes are only expected while the block is idle
// - synchronous active low reset returns the parser to the first size digit,
//   empties the output stages and sets max_line_len to 1024
module chunked_body_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_in_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_chunk_end,
    output logic [31:0] o_body_length,
    output logic [2:0]  o_error_code,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // parse state
    chd_pkg::t_phase                 r_phase, n_phase;
    logic [chd_pkg::LEN_BITS-1:0]    r_rem, n_rem;
    logic [15:0]                     r_line, n_line;
    logic                            r_colon, n_colon;
    logic                            r_only_cr, n_only_cr;
    logic [31:0]                     r_total, n_total;
    logic [15:0]                     r_max_line;

    chd_pkg::t_result                res;
    logic                            res_valid;
    chd_pkg::t_result                out_res;
    logic                            buf_full;
    logic                            in_fire;

    // byte classification and counters, shared by all arms
    chd_pkg::t_hex                   hex;
    logic                            is_lf;
    logic                            is_cr;
    logic                            first;
    logic [15:0]                     line_inc;
    logic [15:0]                     line_next;
    logic                            too_long;
    logic [chd_pkg::LEN_BITS-1:0]    rem_dec;
    logic                            line_phase;

    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_in_stall  = buf_full;
    assign o_cfg_ready = 1'b1;

    assign hex       = chd_pkg::hex_digit(i_in_byte);
    assign is_lf     = (i_in_byte == chd_pkg::CH_LF);
    assign is_cr     = (i_in_byte == chd_pkg::CH_CR);
    assign first     = (r_line == 16'd0);
    // line length saturates so a runaway line keeps failing
    assign line_inc  = (r_line != chd_pkg::LINE_SAT) ? r_line + 16'd1 : r_line;
    assign line_next = is_lf ? r_line : line_inc;
    // the length check comes before any other check of the byte
    assign too_long  = !is_lf && (line_inc >= r_max_line);
    assign rem_dec   = r_rem - {{(chd_pkg::LEN_BITS-1){1'b0}}, 1'b1};
    assign line_phase = (r_phase != chd_pkg::PH_DATA) && (r_phase != chd_pkg::PH_DONE)
                        && (r_phase != chd_pkg::PH_ERROR);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= chd_pkg::MAX_LINE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_line <= i_cfg_data;
        end
    end

    // state register, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= chd_pkg::PH_SIZE_FIRST;
            r_rem     <= '0;
            r_line    <= '0;
            r_colon   <= 1'b0;
            r_only_cr <= 1'b0;
            r_total   <= '0;
        end else if (in_fire) begin
            r_phase   <= n_phase;
            r_rem     <= n_rem;
            r_line    <= n_line;
            r_colon   <= n_colon;
            r_only_cr <= n_only_cr;
            r_total   <= n_total;
        end
    end

    // one parse step per byte
    always_comb begin
        n_phase   = r_phase;
        n_rem     = r_rem;
        n_line    = r_line;
        n_colon   = r_colon;
        n_only_cr = r_only_cr;
        n_total   = r_total;
        res_valid = 1'b0;
        res       = '0;

        if (i_mode) begin
            // restart for a new body
            n_phase   = chd_pkg::PH_SIZE_FIRST;
            n_rem     = '0;
            n_line    = '0;
            n_colon   = 1'b0;
            n_only_cr = 1'b0;
            n_total   = '0;
        end else if (line_phase && too_long) begin
            n_line         = line_next;
            n_phase        = chd_pkg::PH_ERROR;
            res_valid      = 1'b1;
            res.kind       = chd_pkg::KIND_ERROR;
            res.error_code = chd_pkg::ERR_LINE_LONG;
        end else begin
            if (line_phase) begin
                n_line = line_next;
            end
            unique case (r_phase) inside
                chd_pkg::PH_SIZE_FIRST: begin
                    if (!hex.valid) begin
                        n_phase        = chd_pkg::PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = chd_pkg::KIND_ERROR;
                        res.error_code = chd_pkg::ERR_BAD_SIZE;
                    end else begin
                        n_rem   = {{(chd_pkg::LEN_BITS-4){1'b0}}, hex.value};
                        n_phase = chd_pkg::PH_SIZE_DIGITS;
                    end
                end
                chd_pkg::PH_SIZE_DIGITS, chd_pkg::PH_SIZE_EXT: begin
                    if (hex.valid && r_phase == chd_pkg::PH_SIZE_DIGITS) begin
                        // top nibble already used: one more digit overflows
                        if (r_rem[chd_pkg::LEN_BITS-1 -: 4] != 4'd0) begin
                            n_phase        = chd_pkg::PH_ERROR;
                            res_valid      = 1'b1;
                            res.kind       = chd_pkg::KIND_ERROR;
                            res.error_code = chd_pkg::ERR_OVERFLOW;
                        end else begin
                            n_rem = {r_rem[chd_pkg::LEN_BITS-5:0], hex.value};
                        end
                    end else if (!is_lf) begin
                        // extension text up to the line end
                        n_phase = chd_pkg::PH_SIZE_EXT;
                    end else begin
                        // size line ends: zero size opens the trailers
                        n_phase   = (r_rem == '0) ? chd_pkg::PH_TRAILER : chd_pkg::PH_DATA;
                        n_line    = '0;
                        n_colon   = 1'b0;
                        n_only_cr = 1'b0;
                    end
                end
                chd_pkg::PH_DATA: begin
                    n_rem = rem_dec;
                    if (r_total != chd_pkg::TOTAL_SAT) begin
                        n_total = r_total + 32'd1;
                    end
                    if (rem_dec == '0) begin
                        n_phase   = chd_pkg::PH_AFTER_DATA;
                        n_line    = '0;
                        n_colon   = 1'b0;
                        n_only_cr = 1'b0;
                    end
                    res_valid     = 1'b1;
                    res.kind      = chd_pkg::KIND_DATA;
                    res.out_byte  = i_in_byte;
                    res.chunk_end = (rem_dec == '0);
                end
                chd_pkg::PH_AFTER_DATA: begin
                    if (is_lf) begin
                        n_phase   = chd_pkg::PH_SIZE_FIRST;
                        n_line    = '0;
                        n_colon   = 1'b0;
                        n_only_cr = 1'b0;
                    end else if (first && is_cr) begin
                        n_only_cr = 1'b1;
                    end else begin
                        n_phase        = chd_pkg::PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = chd_pkg::KIND_ERROR;
                        res.error_code = chd_pkg::ERR_BAD_TERM;
                    end
                end
                chd_pkg::PH_TRAILER: begin
                    if (!is_lf) begin
                        n_only_cr = first && is_cr;
                        if (i_in_byte == chd_pkg::CH_COLON) begin
                            n_colon = 1'b1;
                        end
                    end else if (first || (r_line == 16'd1 && r_only_cr)) begin
                        // empty line closes the body
                        n_phase         = chd_pkg::PH_DONE;
                        res_valid       = 1'b1;
                        res.kind        = chd_pkg::KIND_DONE;
                        res.body_length = r_total;
                    end else if (!r_colon) begin
                        n_phase        = chd_pkg::PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = chd_pkg::KIND_ERROR;
                        res.error_code = chd_pkg::ERR_NO_COLON;
                    end else begin
                        n_phase   = chd_pkg::PH_TRAILER;
                        n_line    = '0;
                        n_colon   = 1'b0;
                        n_only_cr = 1'b0;
                    end
                end
                chd_pkg::PH_DONE, chd_pkg::PH_ERROR: begin
                    // bytes are dropped until a restart
                end
                default: begin
                end
            endcase
        end
    end

    chd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_fire && res_valid),
        .i_result (res),
        .o_full   (buf_full),
        .o_valid  (o_out_valid),
        .o_result (out_res),
        .i_stall  (i_out_stall)
    );

    assign o_kind        = out_res.kind;
    assign o_out_byte    = out_res.out_byte;
    assign o_chunk_end   = out_res.chunk_end;
    assign o_body_length = out_res.body_length;
    assign o_error_code  = out_res.error_code;

endmodule

// File: rtl/chd_checker.sv
// port-level checker for the chunked body decoder, bound to the top level
// depends on chd_pkg and assert_macros.svh
`include "assert_macros.svh"

module chd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic        o_chunk_end,
    input logic [31:0] o_body_length,
    input logic [2:0]  o_error_code
);

    // a stalled result holds its fields
    `CHD_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_out_byte) && $stable(o_chunk_end) && $stable(o_body_length) && $stable(o_error_code), "stalled result changed")

    // data items carry no length and no error code
    `CHD_ASSERT(a_data_clean, i_clk, i_rst_n, o_out_valid && o_kind == chd_pkg::KIND_DATA |-> o_body_length == 32'd0 && o_error_code == chd_pkg::ERR_NONE, "data item with stray fields")

    // non-error kinds carry no error code; no valid item has kind 3
    `CHD_ASSERT(a_err_code, i_clk, i_rst_n, o_out_valid && o_kind != chd_pkg::KIND_ERROR |-> o_error_code == chd_pkg::ERR_NONE && o_kind != 2'd3, "bad kind or code")

    // reset empties both output stages
    `CHD_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "output not empty after reset")

endmodule

bind chunked_body_decoder chd_checker u_chd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_out_byte    (o_out_byte),
    .o_chunk_end   (o_chunk_end),
    .o_body_length (o_body_length),
    .o_error_code  (o_error_code)
);
